// ----- src/rmf_pkg.sv -----
// Shared constants, register map and control types of the raster median filter.
package rmf_pkg;

    // Default build sizes.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;

    localparam int PIXEL_W  = 8;
    localparam int CFG_W    = 11;
    localparam int HEIGHT_W = 16;
    localparam int RADIUS_W = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0]    RST_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd1;
    localparam logic [RADIUS_W-1:0] RST_RADIUS = 2'd1;

    // Input beat kinds carried on tuser.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Control from the sequencer to the insertion sort unit.
    typedef struct packed {
        logic clear;
        logic insert;
    } rmf_sort_ctl_t;

endpackage

// ----- src/rmf_line_store.sv -----
// Circular line store: one write port and one registered read port.
module rmf_line_store #(
    parameter int DEPTH  = 7168,
    parameter int AW     = 13
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [rmf_pkg::PIXEL_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [rmf_pkg::PIXEL_W-1:0] rd_data
);
    import rmf_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rmf_sort_unit.sv -----
// Insertion sort unit: takes one window pixel per cycle, while insert is set, into a sorted register row.
module rmf_sort_unit #(
    parameter int MAX_RADIUS = 3
) (
    input  logic                        aclk,
    input  rmf_pkg::rmf_sort_ctl_t      ctl,
    input  logic [rmf_pkg::PIXEL_W-1:0] din,
    input  logic [1:0]                  radius,
    output logic [rmf_pkg::PIXEL_W-1:0] median
);
    import rmf_pkg::*;

    localparam int SIDE = 2 * MAX_RADIUS + 1;
    localparam int N    = SIDE * SIDE;
    // Middle ranks of the 3x3, 5x5 and 7x7 windows, kept within the row.
    localparam int MED1 = 4;
    localparam int MED2 = (N > 12) ? 12 : MED1;
    localparam int MED3 = (N > 24) ? 24 : MED1;

    logic [PIXEL_W-1:0] rank_reg [N];

    // Empty places hold the top grey level, so they never sit below real pixels.
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            for (int j = 0; j < N; j++) begin
                rank_reg[j] <= '1;
            end
        end else if (ctl.insert) begin
            // The lowest place takes the new pixel when it is below the current minimum.
            if (rank_reg[0] > din) begin
                rank_reg[0] <= din;
            end
            for (int j = 1; j < N; j++) begin
                if (rank_reg[j] <= din) begin
                    rank_reg[j] <= rank_reg[j];
                end else if (rank_reg[j-1] <= din) begin
                    rank_reg[j] <= din;
                end else begin
                    rank_reg[j] <= rank_reg[j-1];
                end
            end
        end
    end

    // Pick the middle rank for the active window size.
    always_comb begin
        case (radius)
            2'd2:    median = rank_reg[MED2];
            2'd3:    median = rank_reg[MED3];
            default: median = rank_reg[MED1];
        endcase
    end

endmodule

// ----- src/raster_median_filter.sv -----
// Top level of the raster median filter: register port, counters and sequencer.
// Usage notes:
// Grey pixels enter on the s_ channel in raster order, one per beat, with
// s_tuser low; a beat with s_tuser high is a flush that drains one pending
// result once the whole image has been received. Each result beat on the m_
// channel carries the filtered pixel, with m_tlast on the image's final pixel.
// Results trail the input by r rows plus r pixels; pixels within r of an edge
// pass through unchanged, interior ones take the median of the (2r+1)^2 window.
// A border result is read in the border step; for an interior one the
// window pixels are read from the line store one per cycle into the
// insertion sort unit, followed by a drain step. Either way a finish step
// hands the result over. s_tready is low while a result is being worked out.
// A finished result waits in the output register; if the receiver stalls, the
// next result is held back until that register is free.
// The APB port sets width, height and radius; any register write restarts the
// image counters. Write registers only while the block is idle.
// Reset (aresetn low, synchronous) clears the counters and loads width 1024,
// height 1, radius 1; the line store is not cleared and needs no clearing pass.
module raster_median_filter #(
    parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = rmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rmf_pkg::ADDR_W-1:0]  paddr,
    input  logic [rmf_pkg::DATA_W-1:0]  pwdata,
    output logic [rmf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] pixel_value
    input  logic                        s_tuser,  // [0] mode
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // [7:0] filtered_value
    output logic                        m_tlast
);
    import rmf_pkg::*;

    localparam int SR    = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SR);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int DEPTH = SR * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BORDER = 3'd1;
    localparam logic [2:0] ST_SORT   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [CFG_W-1:0]    cfg_width_reg;
    logic [HEIGHT_W-1:0] cfg_height_reg;
    logic [RADIUS_W-1:0] cfg_radius_reg;

    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [1:0]          r_eff;
    logic [LW-1:0]       lag;
    logic [2:0]          two_r;

    logic [2:0]          state_reg;
    logic [CW-1:0]       in_col_reg, out_col_reg, rd_col_reg, base_col_reg;
    logic [HEIGHT_W-1:0] in_row_reg, out_row_reg;
    logic [SW-1:0]       in_slot_reg, out_slot_reg, rd_slot_reg;
    logic                in_done_reg;
    logic [LW-1:0]       dist_reg;
    logic [2:0]          dy_reg, dx_reg;
    logic                ins_reg;
    logic                border_reg;
    logic                m_tvalid_reg, m_tlast_reg;
    logic [PIXEL_W-1:0]  m_tdata_reg;

    logic                cfg_wr, cfg_restart;
    logic                accept, pix_wr, go;
    logic                in_col_wrap, out_col_wrap, out_last, border;
    logic                sort_last_col, out_free;
    logic [SW-1:0]       start_slot;
    logic                rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [PIXEL_W-1:0]  rd_data, median, result;
    rmf_sort_ctl_t       sort_ctl;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_restart = cfg_wr &&
        (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT || paddr[3:2] == REG_RADIUS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_WIDTH;
            cfg_height_reg <= RST_HEIGHT;
            cfg_radius_reg <= RST_RADIUS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  cfg_width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: cfg_height_reg <= pwdata[HEIGHT_W-1:0];
                REG_RADIUS: cfg_radius_reg <= pwdata[RADIUS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = DATA_W'(cfg_width_reg);
            REG_HEIGHT: prdata = DATA_W'(cfg_height_reg);
            REG_RADIUS: prdata = DATA_W'(cfg_radius_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective image geometry, with out-of-range settings clamped.
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_width_reg);
        end
        h_eff = (cfg_height_reg == '0) ? HEIGHT_W'(1) : cfg_height_reg;
        if (cfg_radius_reg == '0) begin
            r_eff = 2'd1;
        end else if (32'(cfg_radius_reg) > 32'(MAX_RADIUS)) begin
            r_eff = 2'(MAX_RADIUS);
        end else begin
            r_eff = cfg_radius_reg;
        end
    end

    assign two_r = {r_eff, 1'b0};
    // Input lead needed before a result: r rows plus r + 1 pixels.
    assign lag = LW'(r_eff) * LW'(w_eff) + LW'(r_eff) + LW'(1);

    // Handshake and item decode.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pix_wr   = accept && (s_tuser == MODE_PIXEL) && !in_done_reg;
    assign go       = accept && ((s_tuser == MODE_FLUSH) ? in_done_reg
                                 : (!in_done_reg && (dist_reg + LW'(1)) >= lag));

    assign in_col_wrap  = ({1'b0, in_col_reg} + WW'(1)) == w_eff;
    assign out_col_wrap = ({1'b0, out_col_reg} + WW'(1)) == w_eff;
    assign out_last     = out_col_wrap && (out_row_reg == h_eff - HEIGHT_W'(1));

    // Border test for the pending result position.
    assign border = (out_row_reg < HEIGHT_W'(r_eff))
        || (({1'b0, out_row_reg} + 17'(r_eff)) >= {1'b0, h_eff})
        || (out_col_reg < CW'(r_eff))
        || (({1'b0, out_col_reg} + WW'(r_eff)) >= w_eff);

    assign start_slot = (out_slot_reg >= SW'(r_eff)) ? (out_slot_reg - SW'(r_eff))
                                                      : (out_slot_reg + SW'(SR) - SW'(r_eff));
    assign sort_last_col = (dx_reg == two_r);
    assign out_free = !m_tvalid_reg || m_tready;

    // Line store addressing.
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_en   = (state_reg == ST_SORT) || (state_reg == ST_BORDER);
    assign rd_addr = (state_reg == ST_SORT)
        ? AW'(rd_slot_reg) * AW'(MAX_WIDTH) + AW'(rd_col_reg)
        : AW'(out_slot_reg) * AW'(MAX_WIDTH) + AW'(out_col_reg);

    rmf_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (pix_wr),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[PIXEL_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sort_ctl.clear  = go;
    assign sort_ctl.insert = ins_reg;

    rmf_sort_unit #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_sort (
        .aclk   (aclk),
        .ctl    (sort_ctl),
        .din    (rd_data),
        .radius (r_eff),
        .median (median)
    );

    assign result = border_reg ? rd_data : median;

    // Sequencer: reads the border pixel or walks the window rows and columns, then hands the result over.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ins_reg   <= 1'b0;
        end else begin
            ins_reg <= (state_reg == ST_SORT);
            case (state_reg)
                ST_IDLE: begin
                    if (go) begin
                        state_reg <= border ? ST_BORDER : ST_SORT;
                    end
                end
                ST_BORDER: state_reg <= ST_FINISH;
                ST_SORT: begin
                    if (sort_last_col && dy_reg == two_r) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:  state_reg <= ST_FINISH;
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Window walk registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && go) begin
            border_reg   <= border;
            dy_reg       <= '0;
            dx_reg       <= '0;
            rd_slot_reg  <= start_slot;
            rd_col_reg   <= out_col_reg - CW'(r_eff);
            base_col_reg <= out_col_reg - CW'(r_eff);
        end else if (state_reg == ST_SORT) begin
            if (sort_last_col) begin
                dx_reg      <= '0;
                dy_reg      <= dy_reg + 3'd1;
                rd_col_reg  <= base_col_reg;
                rd_slot_reg <= (rd_slot_reg == SW'(SR - 1)) ? '0 : rd_slot_reg + SW'(1);
            end else begin
                dx_reg     <= dx_reg + 3'd1;
                rd_col_reg <= rd_col_reg + CW'(1);
            end
        end
    end

    // Input and output position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart
            || (state_reg == ST_FINISH && out_free && out_last)) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            dist_reg     <= '0;
        end else begin
            if (pix_wr) begin
                if (!go) begin
                    dist_reg <= dist_reg + LW'(1);
                end
                if (in_col_wrap) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + HEIGHT_W'(1);
                    in_slot_reg <= (in_slot_reg == SW'(SR - 1)) ? '0 : in_slot_reg + SW'(1);
                    if (({1'b0, in_row_reg} + 17'd1) == {1'b0, h_eff}) begin
                        in_done_reg <= 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (state_reg == ST_FINISH && out_free) begin
                if (out_col_wrap) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + HEIGHT_W'(1);
                    out_slot_reg <= (out_slot_reg == SW'(SR - 1)) ? '0
                                                                   : out_slot_reg + SW'(1);
                end else begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= result;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The input lead never reaches the lag without a result being started.
    a_lead_below_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_reg < lag)
        else $error("input lead reached the window lag");

    // The sort unit only takes data read during the window walk.
    a_insert_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_reg |-> $past(state_reg == ST_SORT))
        else $error("sort insert outside the window walk");

    // A new result only comes from the finishing step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside the finishing step");

    // Row slots stay within the line store.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_slot_reg < SW'(SR)) && (out_slot_reg < SW'(SR)))
        else $error("line store row slot out of range");

endmodule
